// ===== hw/rtl/scfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scfl_pkg;

    localparam int LANES = 4;
    localparam int ANG_W = 32;
    localparam int RES_W = 32;

    // Pipeline depth of one lane, input register to output register
    localparam int LANE_LAT = 11;

    localparam logic [31:0] TINY_LIMIT  = 32'd4096;
    localparam logic [31:0] SMALL_LIMIT = 32'd12582912;
    localparam logic [31:0] RANGE_LIMIT = 32'd1677721600;
    localparam logic [31:0] TWO_OVER_PI = 32'hA2F9836E;
    localparam logic signed [63:0] HALF_PI_Q48 = 64'sh1921FB54442D2;

    localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;
    localparam logic signed [31:0] COEF_S1 = 32'sh0AAAAA20;
    localparam logic signed [31:0] COEF_S2 = 32'sh008883B0;
    localparam logic signed [31:0] COEF_S3 = 32'sh0003329D;
    localparam logic signed [31:0] COEF_C1 = 32'sh1FFFFFE0;
    localparam logic signed [31:0] COEF_C2 = 32'sh02AAAA7C;
    localparam logic signed [31:0] COEF_C3 = 32'sh0016C088;
    localparam logic signed [31:0] COEF_C4 = 32'sh0000664D;

    typedef struct packed {
        logic [LANES-1:0][ANG_W-1:0] angle;
    } t_in_word;

    typedef struct packed {
        logic [LANES-1:0][RES_W-1:0] sine;
        logic [LANES-1:0][RES_W-1:0] cosine;
        logic [LANES-1:0]            range_flags;
    } t_out_word;

    // Q.30 product, rounded half away from zero
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = p + 64'sh20000000 - {63'd0, p[63]};
        return p[61:30];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scfl_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scfl_lane (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic signed [31:0]         i_angle,
    output logic signed [31:0]              o_sine,
    output logic signed [31:0]              o_cosine,
    output logic                            o_far
);
    import scfl_pkg::*;

    // stage 1: magnitude and class
    logic signed [31:0] r_a1;
    logic [31:0]        r_mag1;
    logic               r_small1;
    logic [31:0]        n_mag;
    // stage 2
    logic signed [31:0] r_a2;
    logic [63:0]        r_prod2;
    logic               r_small2;
    // stage 3
    logic signed [31:0] r_a3;
    logic signed [8:0]  r_ns3;
    logic               r_small3;
    logic [63:0]        n_rnd;
    // stage 4
    logic signed [31:0] r_a4;
    logic signed [63:0] r_r4;
    logic               r_small4;
    // stage 5 onwards
    logic signed [31:0] r_x5, r_x6, r_x7, r_x8, r_x9;
    logic signed [63:0] n_rs;
    logic signed [31:0] r_x2_6, r_x2_7;
    logic signed [31:0] r_x3_7, r_x4_7, r_ts3_7, r_tc1_7, r_tc4_7;
    logic signed [31:0] r_x5_8, r_x6_8, r_ps1_8, r_pc2_8, r_sc_8, r_cc_8, r_tc1_8;
    logic signed [31:0] r_p5_9, r_p6_9, r_ps1_9, r_pc2_9, r_tc1_9;
    logic signed [33:0] r_sv10, r_cv10;
    logic signed [31:0] r_x10;
    logic signed [33:0] n_s0, n_c0, n_s1, n_c1;
    logic signed [31:0] r_sine, r_cosine;
    // side pipes
    logic [LANE_LAT-2:0]        r_tiny;
    logic [LANE_LAT-1:0]        r_far;
    logic [1:0]                 r_nb [4:LANE_LAT-1];

    assign n_mag = i_angle[31] ? (32'd0 - i_angle) : i_angle;
    assign n_rnd = r_prod2 + 64'h0080000000000000;
    assign n_rs  = r_r4 + 64'sh20000 - {63'd0, r_r4[63]};

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'(ONE_Q30)) return ONE_Q30;
        if (v < -34'(ONE_Q30)) return -ONE_Q30;
        return v[31:0];
    endfunction

    // swap and negate by quadrant
    always_comb begin
        n_s0 = r_nb[LANE_LAT-1][0] ? r_cv10 : r_sv10;
        n_c0 = r_nb[LANE_LAT-1][0] ? r_sv10 : r_cv10;
        n_s1 = r_nb[LANE_LAT-1][1] ? -n_s0 : n_s0;
        n_c1 = (r_nb[LANE_LAT-1][0] ^ r_nb[LANE_LAT-1][1]) ? -n_c0 : n_c0;
    end

    // advance the whole lane on enable
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1     <= i_angle;
            r_mag1   <= n_mag;
            r_small1 <= n_mag < SMALL_LIMIT;
            r_tiny   <= {r_tiny[LANE_LAT-3:0], n_mag < TINY_LIMIT};
            r_far    <= {r_far[LANE_LAT-2:0], n_mag >= RANGE_LIMIT};

            r_a2     <= r_a1;
            r_prod2  <= 64'(r_mag1) * 64'(TWO_OVER_PI);
            r_small2 <= r_small1;

            r_a3     <= r_a2;
            r_small3 <= r_small2;
            if (r_small2)
                r_ns3 <= 9'sd0;
            else if (r_a2[31])
                r_ns3 <= 9'sd0 - $signed({1'b0, n_rnd[63:56]});
            else
                r_ns3 <= $signed({1'b0, n_rnd[63:56]});

            r_a4     <= r_a3;
            r_small4 <= r_small3;
            r_r4     <= (64'(r_a3) <<< 24) - 64'(r_ns3) * HALF_PI_Q48;
            r_nb[4]  <= r_ns3[1:0];

            // hold the quadrant bits beside the data
            for (int s = 5; s < LANE_LAT; s++) begin
                r_nb[s] <= r_nb[s-1];
            end

            r_x5     <= r_small4 ? (r_a4 <<< 6) : n_rs[49:18];

            r_x6     <= r_x5;
            r_x2_6   <= qmul(r_x5, r_x5);

            r_x7     <= r_x6;
            r_x2_7   <= r_x2_6;
            r_x3_7   <= qmul(r_x2_6, r_x6);
            r_x4_7   <= qmul(r_x2_6, r_x2_6);
            r_ts3_7  <= qmul(r_x2_6, COEF_S3);
            r_tc1_7  <= qmul(r_x2_6, COEF_C1);
            r_tc4_7  <= qmul(r_x2_6, COEF_C4);

            r_x8     <= r_x7;
            r_x5_8   <= qmul(r_x3_7, r_x2_7);
            r_x6_8   <= qmul(r_x4_7, r_x2_7);
            r_ps1_8  <= qmul(r_x3_7, COEF_S1);
            r_pc2_8  <= qmul(r_x4_7, COEF_C2);
            r_sc_8   <= COEF_S2 - r_ts3_7;
            r_cc_8   <= r_tc4_7 - COEF_C3;
            r_tc1_8  <= r_tc1_7;

            r_x9     <= r_x8;
            r_p5_9   <= qmul(r_x5_8, r_sc_8);
            r_p6_9   <= qmul(r_x6_8, r_cc_8);
            r_ps1_9  <= r_ps1_8;
            r_pc2_9  <= r_pc2_8;
            r_tc1_9  <= r_tc1_8;

            r_x10    <= r_x9;
            r_sv10   <= 34'(r_x9) - 34'(r_ps1_9) + 34'(r_p5_9);
            r_cv10   <= 34'(ONE_Q30) - 34'(r_tc1_9) + 34'(r_pc2_9) + 34'(r_p6_9);

            // tiny angles pass straight through
            if (r_tiny[LANE_LAT-2]) begin
                r_sine   <= r_x10;
                r_cosine <= ONE_Q30;
            end else begin
                r_sine   <= sat(n_s1);
                r_cosine <= sat(n_c1);
            end
        end
    end

    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;
    assign o_far    = r_far[LANE_LAT-1];

endmodule

`default_nettype wire

// ===== hw/rtl/sine_cosine_four_lane_top.sv =====
// Each word passes through the lane register pipeline from input accept to output word valid.
// One word per cycle unless stalled; each lane is a fully pipelined multiplier chain.
// Backpressure stalls every stage at once; ready is high whenever the output is free.
// Reset (synchronous, active low) clears only the valid pipeline; data is unaffected.
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_four_lane_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire scfl_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output scfl_pkg::t_out_word     o_out_word
);
    import scfl_pkg::*;

    logic [LANE_LAT-1:0] r_vld;
    logic                n_en;

    assign n_en       = !r_vld[LANE_LAT-1] || i_out_ready;
    assign o_in_ready = n_en;
    assign o_out_valid = r_vld[LANE_LAT-1];

    // advance the valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[LANE_LAT-2:0], i_in_valid};
        end
    end

    // lanes side by side, merged into one word
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        scfl_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (n_en),
            .i_angle  ($signed(i_in_word.angle[l])),
            .o_sine   (o_out_word.sine[l]),
            .o_cosine (o_out_word.cosine[l]),
            .o_far    (o_out_word.range_flags[l])
        );
    end

    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready) else $error("ready low with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("valid after reset");

    a_sine_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out_word.sine[0]) <= ONE_Q30
                      && $signed(o_out_word.sine[0]) >= -ONE_Q30))
        else $error("sine beyond one");

    a_cos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out_word.cosine[0]) <= ONE_Q30
                      && $signed(o_out_word.cosine[0]) >= -ONE_Q30))
        else $error("cosine beyond one");

endmodule

`default_nettype wire
